// ----- src/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants for the I2C transfer sequencer
// Command and result records, phase, opcode, bus action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // Event codes carried by one input beat
    typedef enum logic [1:0] {
        OP_START     = 2'd0,
        OP_COND_DONE = 2'd1,
        OP_BYTE_DONE = 2'd2,
        OP_TICK      = 2'd3
    } t_opcode;

    // Bus action requested toward the pin driver
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_RESTART = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_RELEASE = 3'd4
    } t_action;

    // Completion status reported with finished
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NACK    = 3'd1,
        ST_PROTO   = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_BUSY    = 3'd4
    } t_status;

    // Error recorded during a transfer (busy is never recorded)
    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NACK    = 2'd1,
        ERR_PROTO   = 2'd2,
        ERR_TIMEOUT = 2'd3
    } t_err;

    // Transfer phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_START   = 6'b000010,
        PH_ADDRESS = 6'b000100,
        PH_WRITE   = 6'b001000,
        PH_READ    = 6'b010000,
        PH_STOP    = 6'b100000
    } t_phase;

    localparam logic [7:0]  DUMMY_BYTE = 8'hff;
    localparam logic [15:0] TICK_MAX   = 16'hffff;

    // One input event
    typedef struct packed {
        t_opcode     opcode;
        logic [6:0]  dev_addr;
        logic        is_read;
        logic [15:0] length;
        logic        send_stop;
        logic [15:0] timeout_ticks;
        logic        nack_seen;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } t_cmd;

    // One result beat
    typedef struct packed {
        t_action     bus_action;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        ack_set_valid;
        logic        send_nack;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        finished;
        t_status     status;
        logic [15:0] byte_count;
    } t_result;

endpackage

`default_nettype wire

// ----- src/i2cms_core.sv -----
// ----------------------------------------------------------------------------
// i2cms_core: transfer state and event decoding
// Holds the transfer state and computes the result of one event; the state
// advances on the cycle the event moves into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_core #(
    parameter int LEN_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_fire,
    input  wire i2cms_pkg::t_cmd    i_cmd,
    output i2cms_pkg::t_result      o_res
);

    localparam int EXT_BITS = (LEN_BITS > 16) ? LEN_BITS : 16;

    i2cms_pkg::t_phase   r_phase, n_phase;
    i2cms_pkg::t_err     r_error, n_error;
    logic [LEN_BITS-1:0] r_position, n_position;
    logic [LEN_BITS-1:0] r_total, n_total;
    logic [6:0]          r_target, n_target;
    logic                r_read_mode, n_read_mode;
    logic                r_stop_wanted, n_stop_wanted;
    logic                r_bus_held, n_bus_held;
    logic [15:0]         r_tick_limit, n_tick_limit;
    logic [15:0]         r_ticks, n_ticks;

    logic [LEN_BITS-1:0] pos_inc;
    logic [LEN_BITS-1:0] total_m1;
    logic [15:0]         ticks_inc;
    logic [EXT_BITS-1:0] total_ext;
    logic                do_end;
    i2cms_pkg::t_err     end_err;
    logic                data_fin;
    i2cms_pkg::t_result  res;

    assign pos_inc   = r_position + LEN_BITS'(1);
    assign total_m1  = r_total - LEN_BITS'(1);
    assign ticks_inc = (r_ticks == i2cms_pkg::TICK_MAX) ? r_ticks : r_ticks + 16'd1;
    assign total_ext = EXT_BITS'(r_total);

    // Decode one event against the current phase
    always_comb begin
        n_phase       = r_phase;
        n_error       = r_error;
        n_position    = r_position;
        n_total       = r_total;
        n_target      = r_target;
        n_read_mode   = r_read_mode;
        n_stop_wanted = r_stop_wanted;
        n_bus_held    = r_bus_held;
        n_tick_limit  = r_tick_limit;
        n_ticks       = r_ticks;
        do_end        = 1'b0;
        end_err       = i2cms_pkg::ERR_OK;
        data_fin      = 1'b0;
        res           = '0;
        res.bus_action = i2cms_pkg::ACT_NONE;
        res.status     = i2cms_pkg::ST_OK;

        unique case (i_cmd.opcode)
            i2cms_pkg::OP_START: begin
                if (r_phase != i2cms_pkg::PH_IDLE) begin
                    res.finished = 1'b1;
                    res.status   = i2cms_pkg::ST_BUSY;
                end else begin
                    n_target       = i_cmd.dev_addr;
                    n_read_mode    = i_cmd.is_read;
                    n_total        = LEN_BITS'(i_cmd.length);
                    n_stop_wanted  = i_cmd.send_stop;
                    n_tick_limit   = i_cmd.timeout_ticks;
                    n_ticks        = 16'd0;
                    n_position     = '0;
                    n_error        = i2cms_pkg::ERR_OK;
                    n_phase        = i2cms_pkg::PH_START;
                    res.bus_action = r_bus_held ? i2cms_pkg::ACT_RESTART
                                                : i2cms_pkg::ACT_START;
                    // zero budget times out at once
                    if (i_cmd.timeout_ticks == 16'd0) begin
                        n_error = i2cms_pkg::ERR_TIMEOUT;
                        do_end  = 1'b1;
                        end_err = i2cms_pkg::ERR_TIMEOUT;
                    end
                end
            end
            i2cms_pkg::OP_COND_DONE: begin
                priority if (r_phase == i2cms_pkg::PH_IDLE) begin
                    // ignored while idle
                end else if (r_phase == i2cms_pkg::PH_START) begin
                    n_phase        = i2cms_pkg::PH_ADDRESS;
                    res.send_valid = 1'b1;
                    res.send_byte  = {r_target, r_read_mode};
                end else if (r_phase == i2cms_pkg::PH_STOP) begin
                    n_bus_held     = 1'b0;
                    res.bus_action = i2cms_pkg::ACT_RELEASE;
                    do_end         = 1'b1;
                    end_err        = r_error;
                end else begin
                    n_error = i2cms_pkg::ERR_PROTO;
                    do_end  = 1'b1;
                    end_err = i2cms_pkg::ERR_PROTO;
                end
            end
            i2cms_pkg::OP_BYTE_DONE: begin
                priority if (r_phase == i2cms_pkg::PH_IDLE) begin
                    // ignored while idle
                end else if (i_cmd.nack_seen) begin
                    n_error        = i2cms_pkg::ERR_NACK;
                    n_phase        = i2cms_pkg::PH_STOP;
                    res.bus_action = i2cms_pkg::ACT_STOP;
                end else begin
                    unique case (r_phase)
                        i2cms_pkg::PH_ADDRESS: begin
                            priority if (r_total == '0) begin
                                data_fin = 1'b1;
                            end else if (r_read_mode) begin
                                res.ack_set_valid = 1'b1;
                                res.send_nack     = (r_total == LEN_BITS'(1));
                                n_phase           = i2cms_pkg::PH_READ;
                                res.send_valid    = 1'b1;
                                res.send_byte     = i2cms_pkg::DUMMY_BYTE;
                            end else begin
                                n_phase        = i2cms_pkg::PH_WRITE;
                                res.send_valid = 1'b1;
                                res.send_byte  = i_cmd.tx_byte;
                            end
                        end
                        i2cms_pkg::PH_WRITE: begin
                            n_position = pos_inc;
                            if (pos_inc == r_total) begin
                                data_fin = 1'b1;
                            end else begin
                                res.send_valid = 1'b1;
                                res.send_byte  = i_cmd.tx_byte;
                            end
                        end
                        i2cms_pkg::PH_READ: begin
                            res.read_valid = 1'b1;
                            res.read_byte  = i_cmd.rx_byte;
                            n_position     = pos_inc;
                            if (pos_inc == r_total) begin
                                data_fin = 1'b1;
                            end else begin
                                res.ack_set_valid = 1'b1;
                                res.send_nack     = (pos_inc == total_m1);
                                res.send_valid    = 1'b1;
                                res.send_byte     = i2cms_pkg::DUMMY_BYTE;
                            end
                        end
                        default: begin
                            n_error = i2cms_pkg::ERR_PROTO;
                            do_end  = 1'b1;
                            end_err = i2cms_pkg::ERR_PROTO;
                        end
                    endcase
                end
            end
            i2cms_pkg::OP_TICK: begin
                if (r_phase != i2cms_pkg::PH_IDLE) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= r_tick_limit) begin
                        n_error = i2cms_pkg::ERR_TIMEOUT;
                        do_end  = 1'b1;
                        end_err = i2cms_pkg::ERR_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase

        // End of the data phase: stop or keep the bus
        if (data_fin) begin
            if (r_stop_wanted) begin
                n_phase        = i2cms_pkg::PH_STOP;
                res.bus_action = i2cms_pkg::ACT_STOP;
            end else begin
                n_bus_held = 1'b1;
                do_end     = 1'b1;
                end_err    = i2cms_pkg::ERR_OK;
            end
        end

        // Close the transfer; a failure releases the bus
        if (do_end) begin
            if (end_err != i2cms_pkg::ERR_OK) begin
                res.bus_action = i2cms_pkg::ACT_RELEASE;
                n_bus_held     = 1'b0;
            end else begin
                res.byte_count = total_ext[15:0];
            end
            res.finished = 1'b1;
            res.status   = i2cms_pkg::t_status'({1'b0, end_err});
            n_phase      = i2cms_pkg::PH_IDLE;
        end
    end

    assign o_res = res;

    // Advance state with each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cms_pkg::PH_IDLE;
            r_error       <= i2cms_pkg::ERR_OK;
            r_position    <= '0;
            r_total       <= '0;
            r_target      <= 7'd0;
            r_read_mode   <= 1'b0;
            r_stop_wanted <= 1'b0;
            r_bus_held    <= 1'b0;
            r_tick_limit  <= 16'd0;
            r_ticks       <= 16'd0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_error       <= n_error;
            r_position    <= n_position;
            r_total       <= n_total;
            r_target      <= n_target;
            r_read_mode   <= n_read_mode;
            r_stop_wanted <= n_stop_wanted;
            r_bus_held    <= n_bus_held;
            r_tick_limit  <= n_tick_limit;
            r_ticks       <= n_ticks;
        end
    end

endmodule

`default_nettype wire

// ----- src/i2cms_outbuf.sv -----
// ----------------------------------------------------------------------------
// i2cms_outbuf: result register
// Holds one result beat until the consumer takes it; reloads in the same
// cycle the held beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_outbuf (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire i2cms_pkg::t_result i_res,
    input  wire                     i_ready,
    output logic                    o_valid,
    output i2cms_pkg::t_result      o_res,
    output logic                    o_can_load
);

    logic               r_valid;
    i2cms_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ----- src/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: event-driven I2C master transfer control
// Input register, state update and result register for one transfer.
// ----------------------------------------------------------------------------
// Takes one event beat per clock while input ready is high and returns
// exactly one result beat per event. A beat is captured in the input
// register, decoded combinationally against the transfer state and placed
// in the result register when that register can load; sustained rate is
// one event per clock while the consumer keeps taking results. Input ready
// falls only while both the input and result registers hold beats that
// the consumer has not taken.
`default_nettype none

module i2c_master_transfer_sequencer #(
    parameter int LEN_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // event channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_opcode,
    input  wire  [6:0]  i_dev_addr,
    input  wire         i_is_read,
    input  wire  [15:0] i_length,
    input  wire         i_send_stop,
    input  wire  [15:0] i_timeout_ticks,
    input  wire         i_nack_seen,
    input  wire  [7:0]  i_rx_byte,
    input  wire  [7:0]  i_tx_byte,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_bus_action,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_ack_set_valid,
    output logic        o_send_nack,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_finished,
    output logic [2:0]  o_status,
    output logic [15:0] o_byte_count
);

    logic               r_in_valid;
    i2cms_pkg::t_cmd    r_cmd;
    i2cms_pkg::t_cmd    in_cmd;
    logic               out_can_load;
    logic               advance;
    i2cms_pkg::t_result core_res;
    i2cms_pkg::t_result out_res;

    assign in_cmd = '{
        opcode:        i2cms_pkg::t_opcode'(i_opcode),
        dev_addr:      i_dev_addr,
        is_read:       i_is_read,
        length:        i_length,
        send_stop:     i_send_stop,
        timeout_ticks: i_timeout_ticks,
        nack_seen:     i_nack_seen,
        rx_byte:       i_rx_byte,
        tx_byte:       i_tx_byte
    };

    assign advance    = r_in_valid && out_can_load;
    assign o_in_ready = !r_in_valid || out_can_load;

    // Input register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture the event beat
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= in_cmd;
        end
    end

    i2cms_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_cmd   (r_cmd),
        .o_res   (core_res)
    );

    i2cms_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (core_res),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_res      (out_res),
        .o_can_load (out_can_load)
    );

    // Drive result fields
    assign o_bus_action    = out_res.bus_action;
    assign o_send_valid    = out_res.send_valid;
    assign o_send_byte     = out_res.send_byte;
    assign o_ack_set_valid = out_res.ack_set_valid;
    assign o_send_nack     = out_res.send_nack;
    assign o_read_valid    = out_res.read_valid;
    assign o_read_byte     = out_res.read_byte;
    assign o_finished      = out_res.finished;
    assign o_status        = out_res.status;
    assign o_byte_count    = out_res.byte_count;

endmodule

`default_nettype wire

// ----- src/i2cms_checker.sv -----
// ----------------------------------------------------------------------------
// i2cms_checker: port-level checks for the I2C transfer sequencer
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  i_bus_action,
    input wire        i_send_valid,
    input wire [7:0]  i_send_byte,
    input wire        i_finished,
    input wire [2:0]  i_status,
    input wire [15:0] i_byte_count
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_bus_action) && $stable(i_byte_count))
        else $error("stalled result beat changed");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Failed transfer always releases the bus
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished && (i_status == i2cms_pkg::ST_NACK
            || i_status == i2cms_pkg::ST_PROTO || i_status == i2cms_pkg::ST_TIMEOUT)
        |-> i_bus_action == i2cms_pkg::ACT_RELEASE)
        else $error("error finish without bus release");

    // Count only on an ok finish, byte only with send
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_finished && i_status == i2cms_pkg::ST_OK)
            || i_byte_count == 16'd0) && (i_send_valid || i_send_byte == 8'd0))
        else $error("result field set outside its meaning");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_bus_action (o_bus_action),
    .i_send_valid (o_send_valid),
    .i_send_byte  (o_send_byte),
    .i_finished   (o_finished),
    .i_status     (o_status),
    .i_byte_count (o_byte_count)
);

`default_nettype wire
